// ===== src/gray_world_white_balance_defines.svh =====
// Assertion helpers used by gray_world_white_balance.sv.
`ifndef GRAY_WORLD_WHITE_BALANCE_DEFINES_SVH
`define GRAY_WORLD_WHITE_BALANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GWB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GWB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gwb_pkg.sv =====
package gwb_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 24;
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = GAIN_W - FRAC_BITS;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int DATA_W    = 48;

    localparam logic [GAIN_W-1:0]   GAIN_ONE   = 24'h010000;
    localparam logic [GAIN_W-1:0]   GAIN_MAX   = 24'hFFFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_R_GO,
        ST_GAIN_R_WAIT,
        ST_GAIN_B_GO,
        ST_GAIN_B_WAIT,
        ST_MUL_R,
        ST_MUL_B,
        ST_EMIT
    } gwb_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_ITER,
        DIV_DONE
    } div_state_t;

endpackage

// ===== src/gwb_div.sv =====
// Restoring divider for gain = floor(num * 2^16 / den), saturated to 24 bits.
// One shared compare/subtract step: a saturation check, then one quotient bit a cycle.
module gwb_div import gwb_pkg::*; #(
    parameter int SUM_BITS = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_BITS-1:0] num,
    input  logic [SUM_BITS-1:0] den,
    output logic                done,
    output logic [GAIN_W-1:0]   quot
);

    localparam int CNT_W = $clog2(GAIN_W);
    localparam int IDX_W = $clog2(INT_BITS);

    div_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   rem_reg, rem_next;
    logic [SUM_BITS-1:0]   den_reg, den_next;
    logic [INT_BITS-1:0]   num_lo_reg, num_lo_next;
    logic [GAIN_W-1:0]     quot_reg, quot_next;

    logic [CNT_W-1:0]      idx_full;
    logic                  nbit;
    logic [SUM_BITS:0]     sub_a;
    logic [SUM_BITS+1:0]   diff;
    logic                  ge;

    // Dividend bits 23..16 are the low numerator bits, bits 15..0 are zero.
    assign idx_full = cnt_reg - CNT_W'(FRAC_BITS);
    assign nbit     = (cnt_reg >= CNT_W'(FRAC_BITS)) ? num_lo_reg[idx_full[IDX_W-1:0]] : 1'b0;

    assign sub_a = (state_reg == DIV_ITER) ? {rem_reg, nbit} : {1'b0, rem_reg};
    assign diff  = {1'b0, sub_a} - {2'b00, den_reg};
    assign ge    = ~diff[SUM_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        num_lo_reg <= num_lo_next;
        quot_reg   <= quot_next;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        num_lo_next = num_lo_reg;
        quot_next   = quot_reg;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    den_next    = den;
                    num_lo_next = num[INT_BITS-1:0];
                    rem_next    = {{INT_BITS{1'b0}}, num[SUM_BITS-1:INT_BITS]};
                    state_next  = DIV_CHECK;
                end
            end
            DIV_CHECK: begin
                priority if (den_reg == '0) begin
                    quot_next  = GAIN_ONE;
                    state_next = DIV_DONE;
                end else if (ge) begin
                    quot_next  = GAIN_MAX;
                    state_next = DIV_DONE;
                end else begin
                    cnt_next   = CNT_W'(GAIN_W - 1);
                    state_next = DIV_ITER;
                end
            end
            DIV_ITER: begin
                rem_next  = ge ? diff[SUM_BITS-1:0] : sub_a[SUM_BITS-1:0];
                quot_next = {quot_reg[GAIN_W-2:0], ge};
                if (cnt_reg == '0) begin
                    state_next = DIV_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            DIV_DONE: begin
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign done = (state_reg == DIV_DONE);
    assign quot = quot_reg;

endmodule

// ===== src/gray_world_white_balance.sv =====
// Accumulate pixel: taken one per cycle; the last one holds s_tready low
// while the shared divider forms both gains, 24 quotient bits each.
// Apply pixel: s_tready stays low until its result enters the output register, as the
// single shared 16x24 multiplier scales red, then blue, before the result is emitted.
// Reset (aresetn low, synchronous): clear sums, set both gains to 1.0, drop output valid.
`include "gray_world_white_balance_defines.svh"

module gray_world_white_balance import gwb_pkg::*; #(
    parameter int MAX_PIXELS_LOG2 = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    // pixel request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // red [15:0], green [31:16], blue [47:32]
    input  logic              s_tuser,   // operation [0]: 0 accumulate, 1 apply
    input  logic              s_tlast,
    // balanced pixel channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // red_out [15:0], green_out [31:16], blue_out [47:32]
    output logic              m_tlast
);

    localparam int SUM_BITS = SAMPLE_W + MAX_PIXELS_LOG2;

    gwb_state_t            state_reg, state_next;

    // Channel sums and gains.
    logic [SUM_BITS-1:0]   sum_red_reg, sum_red_next;
    logic [SUM_BITS-1:0]   sum_green_reg, sum_green_next;
    logic [SUM_BITS-1:0]   sum_blue_reg, sum_blue_next;
    logic [GAIN_W-1:0]     gain_red_reg, gain_red_next;
    logic [GAIN_W-1:0]     gain_blue_reg, gain_blue_next;

    // Held apply pixel and scaling pipeline.
    logic [SAMPLE_W-1:0]   red_reg, red_next;
    logic [SAMPLE_W-1:0]   green_reg, green_next;
    logic [SAMPLE_W-1:0]   blue_reg, blue_next;
    logic                  last_reg, last_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SAMPLE_W-1:0]   red_res_reg, red_res_next;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [SAMPLE_W-1:0]   s_red, s_green, s_blue;
    logic                  s_fire;
    logic [SUM_BITS:0]     add_red, add_green, add_blue;
    logic [SAMPLE_W-1:0]   mul_a;
    logic [GAIN_W-1:0]     mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [SAMPLE_W-1:0]   prod_sat;

    logic                  div_start;
    logic [SUM_BITS-1:0]   div_den;
    logic                  div_done;
    logic [GAIN_W-1:0]     div_quot;

    assign s_red   = s_tdata[SAMPLE_W-1:0];
    assign s_green = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign s_blue  = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;

    // Saturating accumulate: the carry out pins a sum at all ones.
    assign add_red   = {1'b0, sum_red_reg}   + (SUM_BITS+1)'(s_red);
    assign add_green = {1'b0, sum_green_reg} + (SUM_BITS+1)'(s_green);
    assign add_blue  = {1'b0, sum_blue_reg}  + (SUM_BITS+1)'(s_blue);

    // Shared multiplier: red gain in the first step, blue gain in the second.
    assign mul_a = (state_reg == ST_MUL_B) ? blue_reg : red_reg;
    assign mul_b = (state_reg == ST_MUL_B) ? gain_blue_reg : gain_red_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Drop the fraction and clamp to the sample range.
    assign prod_sat = (prod_reg[PROD_W-1:SAMPLE_W+FRAC_BITS] != '0) ? SAMPLE_MAX
                                                                    : prod_reg[SAMPLE_W+FRAC_BITS-1:FRAC_BITS];

    assign div_start = (state_reg == ST_GAIN_R_GO) || (state_reg == ST_GAIN_B_GO);
    assign div_den   = (state_reg == ST_GAIN_B_GO) ? sum_blue_reg : sum_red_reg;

    gwb_div #(
        .SUM_BITS(SUM_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_green_reg),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            gain_red_reg  <= GAIN_ONE;
            gain_blue_reg <= GAIN_ONE;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
            gain_red_reg  <= gain_red_next;
            gain_blue_reg <= gain_blue_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        red_res_reg <= red_res_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next     = state_reg;
        sum_red_next   = sum_red_reg;
        sum_green_next = sum_green_reg;
        sum_blue_next  = sum_blue_reg;
        gain_red_next  = gain_red_reg;
        gain_blue_next = gain_blue_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        red_res_next   = red_res_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        // Retire the held result once the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == OP_ACCUM) begin
                        sum_red_next   = add_red[SUM_BITS]   ? '1 : add_red[SUM_BITS-1:0];
                        sum_green_next = add_green[SUM_BITS] ? '1 : add_green[SUM_BITS-1:0];
                        sum_blue_next  = add_blue[SUM_BITS]  ? '1 : add_blue[SUM_BITS-1:0];
                        if (s_tlast) begin
                            state_next = ST_GAIN_R_GO;
                        end
                    end else begin
                        red_next   = s_red;
                        green_next = s_green;
                        blue_next  = s_blue;
                        last_next  = s_tlast;
                        state_next = ST_MUL_R;
                    end
                end
            end
            ST_GAIN_R_GO: begin
                state_next = ST_GAIN_R_WAIT;
            end
            ST_GAIN_R_WAIT: begin
                if (div_done) begin
                    gain_red_next = div_quot;
                    state_next    = ST_GAIN_B_GO;
                end
            end
            ST_GAIN_B_GO: begin
                state_next = ST_GAIN_B_WAIT;
            end
            ST_GAIN_B_WAIT: begin
                // Both gains known: start the next frame from empty sums.
                if (div_done) begin
                    gain_blue_next = div_quot;
                    sum_red_next   = '0;
                    sum_green_next = '0;
                    sum_blue_next  = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_MUL_R: begin
                prod_next  = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                red_res_next = prod_sat;
                prod_next    = mul_p;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free or being drained.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {prod_sat, green_reg, red_res_reg};
                    m_tlast_next  = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `GWB_ASSERT_NEXT(a_last_accum_starts_gain, aclk, aresetn, s_fire && (s_tuser == OP_ACCUM) && s_tlast, state_reg == ST_GAIN_R_GO, "last accumulate pixel did not start the gain pass")
    `GWB_ASSERT_NEXT(a_apply_blocks_input, aclk, aresetn, s_fire && (s_tuser == OP_APPLY), !s_tready, "input taken while an apply pixel is being scaled")
    `GWB_ASSERT_NOW(a_div_done_when_waiting, aclk, aresetn, div_done, (state_reg == ST_GAIN_R_WAIT) || (state_reg == ST_GAIN_B_WAIT), "divider finished outside a gain wait")
    `GWB_ASSERT_NEXT(a_sums_cleared, aclk, aresetn, (state_reg == ST_GAIN_B_WAIT) && div_done, (sum_red_reg == '0) && (sum_green_reg == '0) && (sum_blue_reg == '0), "sums not cleared after gain pass")

endmodule
